### sv/tte_pkg.sv
package tte_pkg;

    localparam int DATA_W     = 32;
    localparam int OFFSET_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STAGES = DATA_W;
    // local sum: utc plus signed offset in seconds, two guard bits
    localparam int LOCAL_W    = DATA_W + 2;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_RATE = 3'd0,
        REG_BASE      = 3'd1,
        REG_REF_TICK  = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_SYNCED    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]   tick_rate_hz;
        logic [DATA_W-1:0]   base_epoch;
        logic [DATA_W-1:0]   reference_tick;
        logic [OFFSET_W-1:0] offset_minutes;
        logic                synced;
    } cfg_t;

endpackage

### sv/tte_regs.sv
module tte_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tte_pkg::DATA_W-1:0]    cfg_wdata,
    output tte_pkg::cfg_t                 cfg
);

    tte_pkg::cfg_t cfg_reg;
    tte_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tte_pkg::reg_idx_t'(cfg_index))
                tte_pkg::REG_TICK_RATE: cfg_next.tick_rate_hz   = cfg_wdata;
                tte_pkg::REG_BASE:      cfg_next.base_epoch     = cfg_wdata;
                tte_pkg::REG_REF_TICK:  cfg_next.reference_tick = cfg_wdata;
                tte_pkg::REG_OFFSET:
                    cfg_next.offset_minutes = cfg_wdata[tte_pkg::OFFSET_W-1:0];
                tte_pkg::REG_SYNCED:    cfg_next.synced         = cfg_wdata[0];
                default:                cfg_next = cfg_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/tte_div.sv
module tte_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [tte_pkg::DATA_W-1:0] now_tick,
    input  tte_pkg::cfg_t              cfg,
    output logic                       q_valid,
    output logic [tte_pkg::DATA_W-1:0] quotient
);

    localparam int W = tte_pkg::DATA_W;
    localparam int N = tte_pkg::DIV_STAGES;

    // entry stage: elapsed ticks, wraps
    logic         ent_valid_reg;
    logic [W-1:0] ent_elapsed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_elapsed_reg <= now_tick - cfg.reference_tick;
    end

    // restoring divider, one quotient bit per stage
    // nq holds the unused dividend bits, shifting out as quotient bits shift in
    logic         st_valid_reg [1:N];
    logic [W-1:0] st_rem_reg   [1:N];
    logic [W-1:0] st_nq_reg    [1:N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic         v_in;
            logic [W-1:0] rem_in;
            logic [W-1:0] nq_in;
            logic [W:0]   trial;
            logic         ge;
            logic [W:0]   diff;
            logic [W-1:0] rem_next;
            logic [W-1:0] nq_next;

            if (k == 0)
            begin : g_first
                // first stage starts from a zero remainder
                assign v_in   = ent_valid_reg;
                assign rem_in = '0;
                assign nq_in  = ent_elapsed_reg;
            end
            else
            begin : g_next
                assign v_in   = st_valid_reg[k];
                assign rem_in = st_rem_reg[k];
                assign nq_in  = st_nq_reg[k];
            end

            always_comb
            begin
                trial    = {rem_in, nq_in[W-1]};
                ge       = (trial >= {1'b0, cfg.tick_rate_hz});
                diff     = trial - {1'b0, cfg.tick_rate_hz};
                rem_next = ge ? diff[W-1:0] : trial[W-1:0];
                nq_next  = {nq_in[W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    st_valid_reg[k+1] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                st_rem_reg[k+1] <= rem_next;
                st_nq_reg[k+1]  <= nq_next;
            end
        end
    endgenerate

    assign q_valid  = st_valid_reg[N];
    assign quotient = st_nq_reg[N];

endmodule

### sv/tte_post.sv
module tte_post (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [tte_pkg::DATA_W-1:0] secs,
    input  tte_pkg::cfg_t              cfg,
    output logic                       done,
    output logic                       valid_res,
    output logic [tte_pkg::DATA_W-1:0] utc_seconds,
    output logic [tte_pkg::DATA_W-1:0] local_seconds_out
);

    localparam int W  = tte_pkg::DATA_W;
    localparam int LW = tte_pkg::LOCAL_W;
    localparam int OW = tte_pkg::OFFSET_W;

    // stage 1: utc with saturation
    logic         u_valid_reg;
    logic [W-1:0] u_utc_reg;
    logic [W:0]   u_sum;
    logic [W-1:0] u_utc_next;

    always_comb
    begin
        u_sum      = {1'b0, cfg.base_epoch} + {1'b0, secs};
        u_utc_next = u_sum[W] ? '1 : u_sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_valid_reg <= 1'b0;
        end
        else
        begin
            u_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        u_utc_reg <= u_utc_next;
    end

    // stage 2: local time, offset * 60 as (x << 6) - (x << 2)
    logic          ok;
    logic [LW-1:0] off_ext;
    logic [LW-1:0] off_sec;
    logic [LW-1:0] loc_sum;
    logic [W-1:0]  loc_next;

    logic          done_reg;
    logic          valid_reg;
    logic [W-1:0]  utc_reg;
    logic [W-1:0]  local_reg;

    always_comb
    begin
        ok      = cfg.synced && (cfg.tick_rate_hz != '0);
        off_ext = {{(LW-OW){cfg.offset_minutes[OW-1]}}, cfg.offset_minutes};
        off_sec = (off_ext << 6) - (off_ext << 2);
        loc_sum = {2'b00, u_utc_reg} + off_sec;
        if (loc_sum[LW-1])
        begin
            loc_next = '0;          // below zero
        end
        else if (loc_sum[LW-2])
        begin
            loc_next = '1;          // past the top
        end
        else
        begin
            loc_next = loc_sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_reg <= ok;
        utc_reg   <= ok ? u_utc_reg : '0;
        local_reg <= ok ? loc_next : '0;
    end

    assign done              = done_reg;
    assign valid_res         = valid_reg;
    assign utc_seconds       = utc_reg;
    assign local_seconds_out = local_reg;

endmodule

### sv/tick_to_epoch_time_top.sv
// tick to epoch time converter
// request channel: pulse start with now_tick; busy stays low, so a request
//   is taken at every clock edge where start is high
// result channel: done is high for exactly one cycle with valid_res,
//   utc_seconds and local_seconds_out; the receiver cannot hold results off
// path: from the accepting edge, the elapsed-tick subtract register, the
//   divider stages, then the add register and the clamp register drive done
// throughput: one request per cycle; the divider is a 32-stage restoring
//   pipeline, one quotient bit per stage
// configuration: cfg_we, cfg_index, cfg_wdata write one register per cycle:
//   0 tick rate, 1 base epoch, 2 reference tick, 3 offset minutes,
//   4 synced; other indexes are ignored
// registers are read live by every stage, so write them only while no
//   request is in flight
// reset: rst_n clears all configuration registers to zero and empties the pipeline
// invalid result (not synced or tick rate zero): all result fields zero
module tick_to_epoch_time_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tte_pkg::DATA_W-1:0]    now_tick,
    output logic                          done,
    output logic                          valid_res,
    output logic [tte_pkg::DATA_W-1:0]    utc_seconds,
    output logic [tte_pkg::DATA_W-1:0]    local_seconds_out,
    input  logic                          cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tte_pkg::DATA_W-1:0]    cfg_wdata
);

    localparam int LATENCY = tte_pkg::DIV_STAGES + 3;

    tte_pkg::cfg_t              cfg;
    logic                       q_valid;
    logic [tte_pkg::DATA_W-1:0] quotient;

    // fully pipelined, never back-pressures a request
    assign busy = 1'b0;

    tte_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // elapsed ticks and the seconds quotient
    tte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .now_tick (now_tick),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .quotient (quotient)
    );

    // base epoch add, offset and clamps
    tte_post u_post (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .secs              (quotient),
        .cfg               (cfg),
        .done              (done),
        .valid_res         (valid_res),
        .utc_seconds       (utc_seconds),
        .local_seconds_out (local_seconds_out)
    );

`ifndef SYNTHESIS
    // every request comes out after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request did not produce a result");

    // no result without a request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a request");

    // invalid results carry zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (utc_seconds == '0 && local_seconds_out == '0))
        else $error("invalid result has nonzero fields");

    // utc never falls below the base epoch
    a_utc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (utc_seconds >= cfg.base_epoch))
        else $error("utc below base epoch");
`endif

endmodule

### sim/tb_tick_to_epoch_time_top.sv
module tb_tick_to_epoch_time_top;

    // seconds per minute, used to scale the local offset
    localparam int SECS_PER_MIN = 60;
    // latency of the block, from a request taken to its result out
    localparam int PIPE_LATENCY = 35;
    // give up waiting for outstanding results after this many cycles
    localparam int DRAIN_LIMIT  = 8 * PIPE_LATENCY;
    // cycles with neither a request taken nor a result out before giving up
    localparam int QUIET_LIMIT  = 2000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 125;

    typedef struct packed {
        logic                       valid;
        logic [tte_pkg::DATA_W-1:0] utc;
        logic [tte_pkg::DATA_W-1:0] local_secs;
    } epoch_result_t;

    // expected-result store plus its own copy of the register file
    class epoch_scoreboard;
        tte_pkg::cfg_t   regs;
        epoch_result_t   pending[$];
        int              errors;

        function new();
            regs    = '0;
            errors  = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // register write as seen on the config port; unknown indexes dropped
        function void write_reg(logic [tte_pkg::CFG_IDX_W-1:0] idx,
                                logic [tte_pkg::DATA_W-1:0] data);
            case (idx)
                tte_pkg::REG_TICK_RATE: regs.tick_rate_hz   = data;
                tte_pkg::REG_BASE:      regs.base_epoch     = data;
                tte_pkg::REG_REF_TICK:  regs.reference_tick = data;
                tte_pkg::REG_OFFSET:
                    regs.offset_minutes = data[tte_pkg::OFFSET_W-1:0];
                tte_pkg::REG_SYNCED:    regs.synced         = data[0];
                default: ;
            endcase
        endfunction

        function epoch_result_t convert_tick(logic [tte_pkg::DATA_W-1:0] now);
            epoch_result_t              r;
            logic [tte_pkg::DATA_W-1:0] elapsed;
            logic [tte_pkg::DATA_W-1:0] secs;
            logic [tte_pkg::DATA_W:0]   sum;
            longint                     off;
            longint                     lsum;
            r = '0;
            if (!regs.synced || regs.tick_rate_hz == '0)
                return r;
            elapsed = now - regs.reference_tick;
            secs    = elapsed / regs.tick_rate_hz;
            sum     = {1'b0, regs.base_epoch} + {1'b0, secs};
            r.valid = 1'b1;
            r.utc   = sum[tte_pkg::DATA_W] ? '1 : sum[tte_pkg::DATA_W-1:0];
            off     = $signed(regs.offset_minutes);
            lsum    = longint'({32'd0, r.utc}) + off * SECS_PER_MIN;
            if (lsum < 0)
                r.local_secs = '0;
            else if (lsum > longint'({32'd0, {tte_pkg::DATA_W{1'b1}}}))
                r.local_secs = '1;
            else
                r.local_secs = lsum[tte_pkg::DATA_W-1:0];
            return r;
        endfunction

        function void note_request(logic [tte_pkg::DATA_W-1:0] now);
            pending.push_back(convert_tick(now));
        endfunction

        task check_result(epoch_result_t got);
            epoch_result_t exp;
            if (pending.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            exp = pending.pop_front();
            if (got.valid !== exp.valid)
                report($sformatf("valid_res got %0b want %0b", got.valid, exp.valid));
            if (got.utc !== exp.utc)
                report($sformatf("utc_seconds got %h want %h", got.utc, exp.utc));
            if (got.local_secs !== exp.local_secs)
                report($sformatf("local_seconds_out got %h want %h",
                                 got.local_secs, exp.local_secs));
        endtask

        task flag_missing();
            while (pending.size() != 0)
            begin
                void'(pending.pop_front());
                report("expected result never came out");
            end
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [tte_pkg::DATA_W-1:0]    now_tick;
    logic                          done;
    logic                          valid_res;
    logic [tte_pkg::DATA_W-1:0]    utc_seconds;
    logic [tte_pkg::DATA_W-1:0]    local_seconds_out;
    logic                          cfg_we;
    logic [tte_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tte_pkg::DATA_W-1:0]    cfg_wdata;

    epoch_scoreboard      sb;
    int                   quiet_cycles;

    tick_to_epoch_time_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .now_tick          (now_tick),
        .done              (done),
        .valid_res         (valid_res),
        .utc_seconds       (utc_seconds),
        .local_seconds_out (local_seconds_out),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #4 clk = ~clk;

    // monitor: everything is sampled at the rising edge, inputs move at the
    // falling edge, so what is seen here is what the block sees
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_wdata);
            if (start && !busy)
                sb.note_request(now_tick);
            if (done)
                sb.check_result({valid_res, utc_seconds, local_seconds_out});
        end
    end

    // watchdog: a hang shows up as a long run of cycles with no traffic
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("tb_tick_to_epoch_time_top: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one request; start stays high when the next request follows directly
    task send_tick(logic [tte_pkg::DATA_W-1:0] value);
        @(negedge clk);
        start    <= 1'b1;
        now_tick <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // wait for all outstanding results, bounded so a lost result is reported
    task drain();
        int n;
        n = 0;
        while (sb.pending.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        sb.flag_missing();
    endtask

    // registers are read live by the pipeline, so only write them once the
    // request stream is stopped and every result is out
    task write_reg(logic [tte_pkg::CFG_IDX_W-1:0] idx, logic [tte_pkg::DATA_W-1:0] data);
        @(negedge clk);
        start <= 1'b0;
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task set_all(logic [tte_pkg::DATA_W-1:0] rate, logic [tte_pkg::DATA_W-1:0] base,
                 logic [tte_pkg::DATA_W-1:0] ref_tick, logic [tte_pkg::DATA_W-1:0] offset,
                 logic [tte_pkg::DATA_W-1:0] sync_word);
        write_reg(tte_pkg::REG_TICK_RATE, rate);
        write_reg(tte_pkg::REG_BASE, base);
        write_reg(tte_pkg::REG_REF_TICK, ref_tick);
        write_reg(tte_pkg::REG_OFFSET, offset);
        write_reg(tte_pkg::REG_SYNCED, sync_word);
    endtask

    // one random phase: random registers, then a stream of tick samples
    // clustered around the reference tick as well as spread over the range
    task random_phase(int p);
        logic [tte_pkg::DATA_W-1:0] rate;
        logic [tte_pkg::DATA_W-1:0] base;
        logic [tte_pkg::DATA_W-1:0] ref_tick;
        logic [tte_pkg::DATA_W-1:0] offset;
        logic [tte_pkg::DATA_W-1:0] sync_word;
        logic [tte_pkg::DATA_W-1:0] t;
        case ($urandom_range(0, 5))
            0: rate = 32'd1;
            1: rate = $urandom_range(2, 64);
            2: rate = 32'd32768;
            3: rate = 32'd1_000_000_000;
            4: rate = $urandom;
            default: rate = '1;
        endcase
        // the first phases pin the extremes of rate and offset
        if (p == 0)
            rate = 32'd1;
        else if (p == 1)
            rate = '1;
        case ($urandom_range(0, 3))
            0, 1: base = $urandom;
            2: base = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            default: base = $urandom_range(0, 50000);
        endcase
        ref_tick  = $urandom;
        // full random word: upper bits exercise the truncation to 11 bits
        offset    = $urandom;
        if (p == 0)
            offset[tte_pkg::OFFSET_W-1:0] = 11'h400;
        else if (p == 1)
            offset[tte_pkg::OFFSET_W-1:0] = 11'h3FF;
        sync_word = $urandom;
        sync_word[0] = 1'b1;
        set_all(rate, base, ref_tick, offset, sync_word);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // phase 2 runs back to back with no gaps at all
            if (p != 2 && $urandom_range(1, 100) <= 28)
                idle_cycles(1);
            case ($urandom_range(0, 3))
                0, 1: t = $urandom;
                2: t = ref_tick + $urandom_range(0, 1000000);
                default: t = ref_tick - $urandom_range(1, 1000);
            endcase
            send_tick(t);
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        now_tick  = '0;
        cfg_we    = 1'b0;
        cfg_index = tte_pkg::REG_TICK_RATE;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // not synced after reset: all fields zero
        send_tick('0);
        send_tick('1);
        // synced but tick rate still zero: still invalid
        write_reg(tte_pkg::REG_SYNCED, 32'd1);
        send_tick(32'h1234_5678);
        // one tick per second, everything at zero: seconds equal ticks
        write_reg(tte_pkg::REG_TICK_RATE, 32'd1);
        send_tick('0);
        send_tick('1);
        // base near the top with the largest nominal offset: local saturates,
        // then utc saturates as well
        write_reg(tte_pkg::REG_OFFSET, 32'd840);
        write_reg(tte_pkg::REG_BASE, 32'hFFFF_FF00);
        send_tick(32'h10);
        send_tick(32'h200);
        // most negative nominal offset with small utc: local clamps at zero;
        // a tick below the reference wraps to a huge elapsed count
        write_reg(tte_pkg::REG_OFFSET, -32'sd720);
        write_reg(tte_pkg::REG_BASE, '0);
        write_reg(tte_pkg::REG_REF_TICK, 32'd100);
        send_tick(32'd150);
        send_tick(32'd50);
        // largest rate; offset written as a wide word keeps its low bits only,
        // giving the most negative 11-bit offset
        set_all('1, 32'd5_000_000, '0, 32'hFFFF_FC00, 32'd1);
        send_tick('1);
        send_tick(32'hFFFF_FFFE);
        send_tick(32'h8000_0000);
        // largest 11-bit offset; synced written with bit 0 clear drops to invalid
        write_reg(tte_pkg::REG_OFFSET, 32'h0000_03FF);
        write_reg(tte_pkg::REG_SYNCED, 32'hFFFF_FFFE);
        send_tick(32'd77);
        write_reg(tte_pkg::REG_SYNCED, 32'd1);
        send_tick(32'd77);
        // writes to indexes past the register list change nothing
        for (int k = 1; k <= 3; k++)
            write_reg(tte_pkg::CFG_IDX_W'(tte_pkg::REG_SYNCED + k), '1);
        send_tick(32'd77);
        // a typical setting: kilohertz counter, recent base epoch
        set_all(32'd1000, 32'd1_700_000_000, 32'hFFFF_0000, 32'd330, 32'd1);
        send_tick(32'hFFFF_0000);
        send_tick(32'h0001_0000);
        send_tick($urandom);
        send_tick($urandom);

        for (int p = 0; p < RAND_PHASES; p++)
            random_phase(p);

        @(negedge clk);
        start <= 1'b0;
        drain();
        // let any stray result still in the pipeline show up
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_tick_to_epoch_time_top: clean");
        else
            $display("tb_tick_to_epoch_time_top: errors");
        $finish;
    end

endmodule
